// File: rtl/lef_pkg.sv
package lef_pkg;

    localparam int CH_W      = 8;    // one color channel
    localparam int CFG_W     = 12;   // image size registers
    localparam int COORD_W   = 11;   // reported centre coordinates
    localparam int CFG_IDX_W = 1;
    localparam int MIN_DIM   = 3;    // smallest usable width / height

    localparam logic [CFG_W-1:0] WIDTH_RST  = 12'd640;
    localparam logic [CFG_W-1:0] HEIGHT_RST = 12'd480;
    localparam logic [CH_W-1:0]  CH_MAX     = 8'hFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH  = 1'b0,
        CFG_IMAGE_HEIGHT = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } t_pix;

    // one window column, three rows
    typedef struct packed {
        t_pix upper;
        t_pix middle;
        t_pix lower;
    } t_column;

    // one line-store word: both stored rows at the same column
    typedef struct packed {
        t_pix upper;
        t_pix middle;
    } t_line;

    localparam int LINE_W = $bits(t_line);

endpackage

// File: rtl/lef_line_mem.sv
module lef_line_mem #(
    parameter int DEPTH = 2048,
    parameter int AW    = 11,
    parameter int DW    = 48
) (
    input  logic          i_clk,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [DW-1:0] o_rd_data,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [DW-1:0] i_wr_data
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/lef_col_cell.sv
module lef_col_cell (
    input  logic             i_clk,
    input  logic             i_shift,
    input  lef_pkg::t_column i_column,
    output lef_pkg::t_column o_column
);

    import lef_pkg::*;

    t_column r_column;

    // takes the neighbor's column on every window shift
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_column <= i_column;
        end
    end

    assign o_column = r_column;

endmodule

// File: rtl/lef_lap.sv
module lef_lap (
    input  logic [lef_pkg::CH_W-1:0] i_up,
    input  logic [lef_pkg::CH_W-1:0] i_left,
    input  logic [lef_pkg::CH_W-1:0] i_centre,
    input  logic [lef_pkg::CH_W-1:0] i_right,
    input  logic [lef_pkg::CH_W-1:0] i_down,
    output logic [lef_pkg::CH_W-1:0] o_result
);

    import lef_pkg::*;

    localparam int SUM_W = CH_W + 3;

    logic [SUM_W-1:0] pos;
    logic [SUM_W-1:0] neg;
    logic [SUM_W-1:0] diff;

    always_comb begin
        // 4 * centre
        pos  = {1'b0, i_centre, 2'b00};
        neg  = SUM_W'(i_up) + SUM_W'(i_down) + SUM_W'(i_left) + SUM_W'(i_right);
        diff = pos - neg;
        if (pos <= neg) begin
            o_result = '0;
        end else if (diff > SUM_W'(CH_MAX)) begin
            o_result = CH_MAX;
        end else begin
            o_result = diff[CH_W-1:0];
        end
    end

endmodule

// File: rtl/laplacian_edge_filter_rgb_core.sv
// Streaming 3x3 Laplacian edge filter for RGB pixels in raster order. Each channel
// gets 4*centre - up - down - left - right, saturated to 0..255. A result beat
// leaves for every input pixel at column >= 2 and row >= 2; it carries the
// centre pixel one row up and one column left, with its coordinates, and
// o_frame_done marks the beat caused by the last pixel of the frame. Border
// pixels give no beat. Throughput is one pixel per clock unless the output
// stalls; line-store read and stage 1 are registered, then the kernel result goes
// into the output register. The rate is set by the line store, which does one read
// and one write per clock. image_width / image_height (index 0 / 1) are taken
// saturated to 3..MAX_WIDTH and 3..MAX_HEIGHT; write them only while the block
// is idle. A change mid-frame takes effect at once and the counters carry on,
// wrapping at their next advance. Line-store entries never written since reset
// read as zero: a fill count tracks the written prefix, so there is no clearing
// pass after reset. o_in_stall follows i_out_stall combinationally whenever the
// output register holds a beat.
module laplacian_edge_filter_rgb_core #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration
    input  logic                          i_cfg_we,
    input  logic [lef_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [lef_pkg::CFG_W-1:0]     i_cfg_data,
    // pixel in
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [lef_pkg::CH_W-1:0]      i_in_red,
    input  logic [lef_pkg::CH_W-1:0]      i_in_green,
    input  logic [lef_pkg::CH_W-1:0]      i_in_blue,
    // result out
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [lef_pkg::CH_W-1:0]      o_out_red,
    output logic [lef_pkg::CH_W-1:0]      o_out_green,
    output logic [lef_pkg::CH_W-1:0]      o_out_blue,
    output logic [lef_pkg::COORD_W-1:0]   o_centre_col,
    output logic [lef_pkg::COORD_W-1:0]   o_centre_row,
    output logic                          o_frame_done
);

    import lef_pkg::*;

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int FILL_W = $clog2(MAX_WIDTH + 1);
    localparam int HFIT_W = $clog2(MAX_HEIGHT + 1);
    localparam int WD_W   = (FILL_W > CFG_W) ? FILL_W : CFG_W;
    localparam int HT_W   = (HFIT_W > CFG_W) ? HFIT_W : CFG_W;

    // ---------------- configuration ----------------
    logic [CFG_W-1:0] r_image_width;
    logic [CFG_W-1:0] r_image_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= WIDTH_RST;
            r_image_height <= HEIGHT_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_IMAGE_WIDTH:  r_image_width  <= i_cfg_data;
                CFG_IMAGE_HEIGHT: r_image_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // saturated frame size
    logic [WD_W-1:0] w_ext, w_sat;
    logic [HT_W-1:0] h_ext, h_sat;

    always_comb begin
        w_ext = WD_W'(r_image_width);
        h_ext = HT_W'(r_image_height);
        if (w_ext < WD_W'(MIN_DIM)) begin
            w_sat = WD_W'(MIN_DIM);
        end else if (w_ext > WD_W'(MAX_WIDTH)) begin
            w_sat = WD_W'(MAX_WIDTH);
        end else begin
            w_sat = w_ext;
        end
        if (h_ext < HT_W'(MIN_DIM)) begin
            h_sat = HT_W'(MIN_DIM);
        end else if (h_ext > HT_W'(MAX_HEIGHT)) begin
            h_sat = HT_W'(MAX_HEIGHT);
        end else begin
            h_sat = h_ext;
        end
    end

    // ---------------- handshake ----------------
    logic r_out_valid;
    logic en;      // whole pipeline moves
    logic fire;    // input beat taken

    assign en         = !r_out_valid || !i_out_stall;
    assign o_in_stall = !en;
    assign fire       = i_in_valid && en;

    // ---------------- stage 0: position counters, line-store read ----------------
    logic [COL_W-1:0]  r_col;
    logic [ROW_W-1:0]  r_row;
    logic [FILL_W-1:0] r_fill;   // entries 0..r_fill-1 of the line store are written
    logic              col_last, row_last, emit, hit;

    always_comb begin
        col_last = ((WD_W + 1)'(r_col) + (WD_W + 1)'(1)) >= (WD_W + 1)'(w_sat);
        row_last = ((HT_W + 1)'(r_row) + (HT_W + 1)'(1)) >= (HT_W + 1)'(h_sat);
        emit     = (r_col >= COL_W'(2)) && (r_row >= ROW_W'(2));
        hit      = FILL_W'(r_col) < r_fill;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_fill <= '0;
        end else if (fire) begin
            if (col_last) begin
                r_col <= '0;
                r_row <= row_last ? '0 : r_row + ROW_W'(1);
            end else begin
                r_col <= r_col + COL_W'(1);
            end
            // written entries always form a prefix; grow it when we write past it
            if (FILL_W'(r_col) == r_fill) begin
                r_fill <= r_fill + FILL_W'(1);
            end
        end
    end

    // stage 1 registers
    logic               r_s1_valid;
    logic               r_s1_emit;
    logic               r_s1_done;
    logic               r_s1_hit;
    t_pix               r_s1_px;
    logic [COL_W-1:0]   r_s1_col;
    logic [COORD_W-1:0] r_s1_ccol;
    logic [COORD_W-1:0] r_s1_crow;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (en) begin
            r_s1_valid <= fire;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_s1_emit      <= emit;
            r_s1_done      <= col_last && row_last;
            r_s1_hit       <= hit;
            r_s1_px.red    <= i_in_red;
            r_s1_px.green  <= i_in_green;
            r_s1_px.blue   <= i_in_blue;
            r_s1_col       <= r_col;
            r_s1_ccol      <= COORD_W'(r_col - COL_W'(1));
            r_s1_crow      <= COORD_W'(r_row - ROW_W'(1));
        end
    end

    // ---------------- line store ----------------
    logic [LINE_W-1:0] rd_word;
    t_line             rd_line;
    t_line             wr_line;
    t_pix              top_px, mid_px;
    logic              shift;

    assign shift   = en && r_s1_valid;
    assign rd_line = t_line'(rd_word);

    // unwritten entries read as zero
    assign top_px = r_s1_hit ? rd_line.upper  : '0;
    assign mid_px = r_s1_hit ? rd_line.middle : '0;

    // rows move up by one at this column
    assign wr_line.upper  = mid_px;
    assign wr_line.middle = r_s1_px;

    lef_line_mem #(
        .DEPTH (MAX_WIDTH),
        .AW    (COL_W),
        .DW    (LINE_W)
    ) u_line_mem (
        .i_clk     (i_clk),
        .i_rd_en   (fire),
        .i_rd_addr (r_col),
        .o_rd_data (rd_word),
        .i_wr_en   (shift),
        .i_wr_addr (r_s1_col),
        .i_wr_data (LINE_W'(wr_line))
    );

    // ---------------- window: chain of column cells ----------------
    // new column -> cell 0 (current column - 1) -> cell 1 (current column - 2)
    t_column new_col, near_col, far_col;

    assign new_col.upper  = top_px;
    assign new_col.middle = mid_px;
    assign new_col.lower  = r_s1_px;

    lef_col_cell u_cell_near (
        .i_clk    (i_clk),
        .i_shift  (shift),
        .i_column (new_col),
        .o_column (near_col)
    );

    lef_col_cell u_cell_far (
        .i_clk    (i_clk),
        .i_shift  (shift),
        .i_column (near_col),
        .o_column (far_col)
    );

    // ---------------- kernel, one per channel ----------------
    // centre sits in the near cell's middle row; right is the fresh middle-row pixel
    t_pix lap_px;

    lef_lap u_lap_red (
        .i_up     (near_col.upper.red),
        .i_left   (far_col.middle.red),
        .i_centre (near_col.middle.red),
        .i_right  (mid_px.red),
        .i_down   (near_col.lower.red),
        .o_result (lap_px.red)
    );

    lef_lap u_lap_green (
        .i_up     (near_col.upper.green),
        .i_left   (far_col.middle.green),
        .i_centre (near_col.middle.green),
        .i_right  (mid_px.green),
        .i_down   (near_col.lower.green),
        .o_result (lap_px.green)
    );

    lef_lap u_lap_blue (
        .i_up     (near_col.upper.blue),
        .i_left   (far_col.middle.blue),
        .i_centre (near_col.middle.blue),
        .i_right  (mid_px.blue),
        .i_down   (near_col.lower.blue),
        .o_result (lap_px.blue)
    );

    // ---------------- output register ----------------
    t_pix               r_out_px;
    logic [COORD_W-1:0] r_out_ccol;
    logic [COORD_W-1:0] r_out_crow;
    logic               r_out_done;
    logic               load_out;

    assign load_out = r_s1_valid && r_s1_emit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= load_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && load_out) begin
            r_out_px   <= lap_px;
            r_out_ccol <= r_s1_ccol;
            r_out_crow <= r_s1_crow;
            r_out_done <= r_s1_done;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_red    = r_out_px.red;
    assign o_out_green  = r_out_px.green;
    assign o_out_blue   = r_out_px.blue;
    assign o_centre_col = r_out_ccol;
    assign o_centre_row = r_out_crow;
    assign o_frame_done = r_out_done;

    // ---------------- checks ----------------
`ifndef SYNTHESIS
    // a held result beat is never dropped
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> r_out_valid)
        else $error("result beat lost while stalled");

    // the column being read never lies beyond the written prefix plus one
    a_fill_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        FILL_W'(r_col) <= r_fill)
        else $error("column counter ahead of line-store fill");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_W'(MAX_WIDTH))
        else $error("line-store fill count overflow");

    // an accepted pixel always reaches stage 1 on the next edge
    a_s1_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> r_s1_valid)
        else $error("accepted pixel missing from stage 1");
`endif

endmodule

// File: bench/lef_edge_checker.sv
`timescale 1ns / 1ps

module lef_edge_checker #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [lef_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [lef_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                          i_in_valid,
    input  logic                          i_in_stall,
    input  logic [lef_pkg::CH_W-1:0]      i_in_red,
    input  logic [lef_pkg::CH_W-1:0]      i_in_green,
    input  logic [lef_pkg::CH_W-1:0]      i_in_blue,
    input  logic                          i_out_valid,
    input  logic                          i_out_stall,
    input  logic [lef_pkg::CH_W-1:0]      i_out_red,
    input  logic [lef_pkg::CH_W-1:0]      i_out_green,
    input  logic [lef_pkg::CH_W-1:0]      i_out_blue,
    input  logic [lef_pkg::COORD_W-1:0]   i_centre_col,
    input  logic [lef_pkg::COORD_W-1:0]   i_centre_row,
    input  logic                          i_frame_done,
    output int                            o_fails,
    output int                            o_pending
);

    import lef_pkg::*;

    typedef struct packed {
        t_pix               pix;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic               done;
    } t_edge_beat;

    // filter state
    t_pix               line_upper  [MAX_WIDTH];
    t_pix               line_middle [MAX_WIDTH];
    t_column            win_prev;
    t_column            win_curr;
    logic [COORD_W-1:0] col_pos;
    logic [COORD_W-1:0] row_pos;
    logic [CFG_W-1:0]   width_reg;
    logic [CFG_W-1:0]   height_reg;

    t_edge_beat         beats_due[$];
    int                 fails = 0;

    function automatic int clamp_dim(input int v, input int hi);
        if (v < MIN_DIM) return MIN_DIM;
        if (v > hi) return hi;
        return v;
    endfunction

    // 4*c - u - d - l - r, saturated to one channel
    function automatic logic [CH_W-1:0] lap(input int c, input int u, input int d,
                                            input int l, input int r);
        int s;
        s = 4 * c - u - d - l - r;
        if (s < 0) s = 0;
        if (s > int'(CH_MAX)) s = int'(CH_MAX);
        return s[CH_W-1:0];
    endfunction

    task automatic filter_pixel(input t_pix px);
        int         w;
        int         h;
        int         idx;
        t_pix       top;
        t_pix       mid;
        t_pix       up;
        t_pix       left;
        t_pix       centre;
        t_pix       down;
        logic       col_last;
        logic       row_last;
        t_edge_beat beat;
        w        = clamp_dim(int'(width_reg), MAX_WIDTH);
        h        = clamp_dim(int'(height_reg), MAX_HEIGHT);
        idx      = (col_pos < MAX_WIDTH) ? int'(col_pos) : MAX_WIDTH - 1;
        top      = line_upper[idx];
        mid      = line_middle[idx];
        col_last = (int'(col_pos) + 1 >= w);
        row_last = (int'(row_pos) + 1 >= h);
        if (col_pos >= 2 && row_pos >= 2) begin
            up             = win_curr.upper;
            left           = win_prev.middle;
            centre         = win_curr.middle;
            down           = win_curr.lower;
            beat.pix.red   = lap(centre.red, up.red, down.red, left.red, mid.red);
            beat.pix.green = lap(centre.green, up.green, down.green, left.green, mid.green);
            beat.pix.blue  = lap(centre.blue, up.blue, down.blue, left.blue, mid.blue);
            beat.col       = col_pos - 1'b1;
            beat.row       = row_pos - 1'b1;
            beat.done      = col_last && row_last;
            beats_due.push_back(beat);
        end
        win_prev          = win_curr;
        win_curr          = '{upper: top, middle: mid, lower: px};
        line_upper[idx]   = mid;
        line_middle[idx]  = px;
        if (col_last) begin
            col_pos = '0;
            row_pos = row_last ? '0 : row_pos + 1'b1;
        end else begin
            col_pos = col_pos + 1'b1;
        end
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            fails++;
            $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_edge_beat want;
        if (!i_rst_n) begin
            for (int k = 0; k < MAX_WIDTH; k++) begin
                line_upper[k]  = '0;
                line_middle[k] = '0;
            end
            win_prev   = '0;
            win_curr   = '0;
            col_pos    = '0;
            row_pos    = '0;
            width_reg  = WIDTH_RST;
            height_reg = HEIGHT_RST;
            beats_due.delete();
        end else begin
            // a pixel sees the size in force before a write on the same edge
            if (i_in_valid && !i_in_stall)
                filter_pixel('{red: i_in_red, green: i_in_green, blue: i_in_blue});
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_IMAGE_WIDTH) width_reg = i_cfg_data;
                else if (i_cfg_index == CFG_IMAGE_HEIGHT) height_reg = i_cfg_data;
            end
            if (i_out_valid && !i_out_stall) begin
                if (beats_due.size() == 0) begin
                    fails++;
                    $display("%0t ns: beat expected none, got col %0d row %0d rgb %0d %0d %0d",
                             $time, i_centre_col, i_centre_row,
                             i_out_red, i_out_green, i_out_blue);
                end else begin
                    want = beats_due.pop_front();
                    check_field("red", want.pix.red, i_out_red);
                    check_field("green", want.pix.green, i_out_green);
                    check_field("blue", want.pix.blue, i_out_blue);
                    check_field("centre_col", want.col, i_centre_col);
                    check_field("centre_row", want.row, i_centre_row);
                    check_field("frame_done", want.done, i_frame_done);
                end
            end
        end
        o_pending <= beats_due.size();
        o_fails   <= fails;
    end

endmodule

// File: bench/tb_laplacian_edge_filter_rgb_core.sv
`timescale 1ns / 1ps

module tb_laplacian_edge_filter_rgb_core;
    import lef_pkg::*;

    localparam int MAX_WIDTH    = 2048;
    localparam int MAX_HEIGHT   = 2048;
    localparam int RAND_PIXELS  = 1650;
    localparam int DRAIN_CYCLES = 16;      // well past the pipeline
    localparam int HOLD_CYCLES  = 150;     // long output hold-off
    localparam int CYCLE_LIMIT  = 400000;

    // hand-built 4x3 frame, raster order, packed R G B.
    // red: centre (1,1) is 255 with zero neighbours -> clips high,
    //      centre (2,1) is 0 with 255 neighbours -> clips low.
    // green: mid-range values, no clipping (60 and 80).
    // blue: inverse of red, so the two clip cases swap.
    localparam t_pix FRAME_A [12] = '{
        24'h1101EE, 24'h005AFF, 24'hFF6E00, 24'h63029C,
        24'h0032FF, 24'hFF6400, 24'h0078FF, 24'hFF3C00,
        24'h2103DE, 24'h0050FF, 24'hFF8200, 24'hC80437
    };

    logic                 clk        = 1'b0;
    logic                 rst_n      = 1'b0;
    logic                 cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index  = CFG_IMAGE_WIDTH;
    logic [CFG_W-1:0]     cfg_data   = '0;
    logic                 in_valid   = 1'b0;
    logic                 in_stall;
    logic [CH_W-1:0]      in_red     = '0;
    logic [CH_W-1:0]      in_green   = '0;
    logic [CH_W-1:0]      in_blue    = '0;
    logic                 out_valid;
    logic                 out_stall  = 1'b0;
    logic [CH_W-1:0]      out_red;
    logic [CH_W-1:0]      out_green;
    logic [CH_W-1:0]      out_blue;
    logic [COORD_W-1:0]   centre_col;
    logic [COORD_W-1:0]   centre_row;
    logic                 frame_done;

    int                   fails;
    int                   pending;
    int                   src_idle   = 0;   // sender gap chance, percent
    int                   rx_idle    = 0;   // receiver stall chance, percent
    logic                 hold_armed = 1'b0;
    logic                 hold_used  = 1'b0;
    int                   hold_left  = 0;
    int                   cycles     = 0;

    initial begin
        forever #5 clk = ~clk;
    end

    laplacian_edge_filter_rgb_core #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) uut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (in_valid),
        .o_in_stall   (in_stall),
        .i_in_red     (in_red),
        .i_in_green   (in_green),
        .i_in_blue    (in_blue),
        .o_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .o_out_red    (out_red),
        .o_out_green  (out_green),
        .o_out_blue   (out_blue),
        .o_centre_col (centre_col),
        .o_centre_row (centre_row),
        .o_frame_done (frame_done)
    );

    // scoreboard: predicts every result beat and compares in order
    lef_edge_checker #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) edge_chk (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_red     (in_red),
        .i_in_green   (in_green),
        .i_in_blue    (in_blue),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_red    (out_red),
        .i_out_green  (out_green),
        .i_out_blue   (out_blue),
        .i_centre_col (centre_col),
        .i_centre_row (centre_row),
        .i_frame_done (frame_done),
        .o_fails      (fails),
        .o_pending    (pending)
    );

    // Result side. Random stalls at rx_idle percent, plus one long hold-off
    // once armed: the output register fills, o_in_stall rises and the sender
    // has to sit on its beat.
    always @(posedge clk) begin
        if (hold_left != 0) begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (hold_armed && !hold_used) begin
            out_stall <= 1'b1;
            hold_left <= HOLD_CYCLES;
            hold_used <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(0, 99) < rx_idle);
        end
    end

    // watchdog
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // One pixel beat: random gaps first, then hold valid and payload until
    // the block takes it. Valid is never lowered while a beat is offered.
    task automatic send_pixel(input t_pix px);
        while ($urandom_range(0, 99) < src_idle) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_red   <= px.red;
        in_green <= px.green;
        in_blue  <= px.blue;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    // Both registers, back to back; only called with the block idle.
    task automatic set_size(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_IMAGE_WIDTH;
        cfg_data  <= w;
        @(posedge clk);
        cfg_index <= CFG_IMAGE_HEIGHT;
        cfg_data  <= h;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Drain: every predicted beat back, then a few clocks more since border
    // pixels leave nothing to wait on but may still be in the pipeline.
    task automatic wait_idle();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Channel value: hard extremes, a smooth patch around base, or anything.
    function automatic logic [CH_W-1:0] rand_level(input int base);
        int v;
        case ($urandom_range(0, 9))
            0, 1: return $urandom_range(0, 1) ? CH_MAX : '0;
            2, 3, 4: begin
                v = base + int'($urandom_range(0, 16)) - 8;
                if (v < 0) v = 0;
                if (v > int'(CH_MAX)) v = int'(CH_MAX);
                return v[CH_W-1:0];
            end
            default: return CH_W'($urandom_range(0, 255));
        endcase
    endfunction

    // Size values off the beaten path: below the minimum, the minimum,
    // all ones (saturates to the maximum), or any 12-bit value.
    function automatic logic [CFG_W-1:0] odd_dim();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return CFG_W'(1);
            2: return CFG_W'(2);
            3: return CFG_W'(MIN_DIM);
            4: return '1;
            default: return CFG_W'($urandom);
        endcase
    endfunction

    initial begin : stimulus
        int sent;
        int phase;
        int n;
        int base_r;
        int base_g;
        int base_b;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed: clip high / clip low / mid-range on a 4x3 frame,
        // frame end on its second result
        set_size(CFG_W'(4), CFG_W'(3));
        for (int k = 0; k < 12; k++) send_pixel(FRAME_A[k]);
        wait_idle();

        // out-of-range sizes, both taken as 3x3: a single result per frame
        set_size(CFG_W'(0), CFG_W'(2));
        for (int k = 0; k < 9; k++)
            send_pixel('{red: rand_level(128), green: rand_level(128), blue: rand_level(128)});
        wait_idle();

        // --- random phases; sizes change between phases, often mid-frame,
        // so the counters carry on and wrap under the new size
        sent  = 0;
        phase = 0;
        while (sent < RAND_PIXELS) begin
            case (phase % 4)
                0: begin src_idle = 0;  rx_idle <= 0;  end
                1: begin src_idle = 58; rx_idle <= 0;  end
                2: begin src_idle = 0;  rx_idle <= 58; end
                default: begin src_idle = 23; rx_idle <= 23; end
            endcase

            if (phase == 1) begin
                // narrow and tall: pushes the row counter past 2
                set_size(CFG_W'(MIN_DIM), '1);
                n = 12;
            end else if (phase == 2) begin
                // widen mid-frame: results far out along the row, mostly
                // against line-store entries never written
                set_size(12'd2048, 12'd2048);
                n = 700;
            end else if (phase == 4) begin
                // small frame: results come early, so the hold-off backs up
                set_size(CFG_W'(8), CFG_W'(8));
                n = 120;
            end else if (phase == 6) begin
                set_size('1, CFG_W'(MIN_DIM));
                n = 60;
            end else begin
                n = $urandom_range(20, 120);
                case ($urandom_range(0, 7))
                    0: set_size(odd_dim(), CFG_W'($urandom_range(3, 10)));
                    1: set_size(CFG_W'($urandom_range(3, 16)), odd_dim());
                    2: ;    // keep the size, frame picks up where it stopped
                    default: set_size(CFG_W'($urandom_range(3, 24)),
                                      CFG_W'($urandom_range(3, 10)));
                endcase
            end

            // long output hold-off while the sender runs with no gaps
            if (phase == 4) hold_armed <= 1'b1;

            base_r = $urandom_range(0, 255);
            base_g = $urandom_range(0, 255);
            base_b = $urandom_range(0, 255);
            for (int k = 0; k < n; k++) begin
                send_pixel('{red:   rand_level(base_r),
                             green: rand_level(base_g),
                             blue:  rand_level(base_b)});
                sent++;
            end
            wait_idle();
            phase++;
        end

        if (fails == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/lef_pkg.sv
rtl/lef_line_mem.sv
rtl/lef_col_cell.sv
rtl/lef_lap.sv
rtl/laplacian_edge_filter_rgb_core.sv
bench/lef_edge_checker.sv
bench/tb_laplacian_edge_filter_rgb_core.sv
